// ===== hw/rtl/scc_pkg.sv =====
// shared types, constants and channel tables of the sensor channel conditioner
// no dependencies; imported by every module of the block
package scc_pkg;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CNT_W      = 3;
  localparam int QUO_W      = VAL_W + 1;
  localparam int REM_W      = 3;
  localparam int ALPHA_W    = 9;

  localparam int OVERSAMPLE = 5;
  localparam logic signed [VAL_W-1:0] FAIL_CODE = 16'sh8000;

  localparam logic [ALPHA_W-1:0] ALPHA_PRESSURE = 9'd64;
  localparam logic [ALPHA_W-1:0] ALPHA_OIL_TEMP = 9'd64;
  localparam logic [ALPHA_W-1:0] ALPHA_VOLTAGE  = 9'd64;
  localparam logic [ALPHA_W-1:0] ALPHA_OUTSIDE  = 9'd64;

  localparam logic [CH_W-1:0] CH_PRESSURE = 2'd0;
  localparam logic [CH_W-1:0] CH_OIL_TEMP = 2'd1;
  localparam logic [CH_W-1:0] CH_VOLTAGE  = 2'd2;
  localparam logic [CH_W-1:0] CH_OUTSIDE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LO = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_HI = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OIL_TEMP_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OIL_TEMP_HI = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_LO  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_HI  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_LO  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_HI  = 4'd7;

  localparam logic signed [VAL_W-1:0] LO_RESET [NUM_CH] =
    '{16'sd0, 16'sd5000, 16'sd1000, -16'sd4000};
  localparam logic signed [VAL_W-1:0] HI_RESET [NUM_CH] =
    '{16'sd1000, 16'sd15000, 16'sd1600, 16'sd6000};

  // floor division of an offset 16-bit value by the block length
  localparam int DIV_RSH = 19;
  localparam logic [DIV_RSH:0] DIV_RECIP = (DIV_RSH+1)'((1 << DIV_RSH) / OVERSAMPLE + 1);
  localparam logic [VAL_W-1:0] DIV_D     = VAL_W'(OVERSAMPLE);
  localparam logic [QUO_W-1:0] DIV_OFS_Q = QUO_W'(32768 / OVERSAMPLE);
  localparam logic [REM_W:0]   DIV_OFS_R = (REM_W+1)'(32768 % OVERSAMPLE);
  localparam logic [REM_W:0]   OS_REM    = (REM_W+1)'(OVERSAMPLE);
  localparam logic [CNT_W-1:0] OS_CNT    = CNT_W'(OVERSAMPLE);

  typedef enum logic [1:0] {
    DISP_NONE     = 2'd0,
    DISP_BELOW    = 2'd1,
    DISP_IN_RANGE = 2'd2,
    DISP_ABOVE    = 2'd3
  } disp_e;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]         out_channel;
    logic signed [VAL_W-1:0] filtered_value;
    logic [1:0]              display_status;
    logic signed [VAL_W-1:0] shown_value;
    logic                    new_average;
  } out_word_t;

  // per-channel state record held in the state memory
  typedef struct packed {
    logic signed [VAL_W-1:0] filt;
    logic                    primed;
    logic [CNT_W-1:0]        count;
    logic signed [QUO_W-1:0] quo;
    logic [REM_W-1:0]        rem;
    disp_e                   status;
    logic signed [VAL_W-1:0] shown;
  } rec_t;

  // sample-only work done ahead of the state read
  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic                    fail;
    logic signed [VAL_W-1:0] raw;
    disp_e                   region;
    logic signed [QUO_W-1:0] quo;
    logic [REM_W-1:0]        rem;
    logic signed [VAL_W-1:0] reload;
  } prep_t;

  localparam rec_t REC_RESET = '{
    filt: '0, primed: 1'b0, count: '0, quo: '0, rem: '0,
    status: DISP_NONE, shown: '0
  };

  function automatic logic [ALPHA_W-1:0] alpha_of(input logic [CH_W-1:0] ch);
    logic [ALPHA_W-1:0] a;
    unique case (ch)
      CH_PRESSURE: a = ALPHA_PRESSURE;
      CH_OIL_TEMP: a = ALPHA_OIL_TEMP;
      CH_VOLTAGE:  a = ALPHA_VOLTAGE;
      default:     a = ALPHA_OUTSIDE;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/scc_prep.sv =====
// limit registers and the sample-only front end: fail detect, clamp, block split
// depends on scc_pkg
module scc_prep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic signed [scc_pkg::VAL_W-1:0]      cfg_data_i,
  input  scc_pkg::in_word_t                     in_word_i,
  output scc_pkg::prep_t                        prep_o
);
  import scc_pkg::*;

  logic signed [VAL_W-1:0] lo_q [NUM_CH];
  logic signed [VAL_W-1:0] hi_q [NUM_CH];

  logic signed [VAL_W-1:0] lo, hi, s, clamped;
  disp_e                   region;
  logic [VAL_W-1:0]        u, q_u, qd;
  logic [VAL_W+DIV_RSH:0]  prod;
  logic [REM_W-1:0]        r_u;
  logic signed [REM_W:0]   r_t;
  logic signed [QUO_W-1:0] q_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        lo_q[i] <= LO_RESET[i];
        hi_q[i] <= HI_RESET[i];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESSURE_LO: lo_q[CH_PRESSURE] <= cfg_data_i;
        CFG_PRESSURE_HI: hi_q[CH_PRESSURE] <= cfg_data_i;
        CFG_OIL_TEMP_LO: lo_q[CH_OIL_TEMP] <= cfg_data_i;
        CFG_OIL_TEMP_HI: hi_q[CH_OIL_TEMP] <= cfg_data_i;
        CFG_VOLTAGE_LO:  lo_q[CH_VOLTAGE]  <= cfg_data_i;
        CFG_VOLTAGE_HI:  hi_q[CH_VOLTAGE]  <= cfg_data_i;
        CFG_OUTSIDE_LO:  lo_q[CH_OUTSIDE]  <= cfg_data_i;
        CFG_OUTSIDE_HI:  hi_q[CH_OUTSIDE]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lo = lo_q[in_word_i.channel];
  assign hi = hi_q[in_word_i.channel];
  assign s  = in_word_i.sample;

  always_comb begin
    if (s < lo) begin
      clamped = lo;
      region  = DISP_BELOW;
    end else if (s <= hi) begin
      clamped = s;
      region  = DISP_IN_RANGE;
    end else begin
      clamped = hi;
      region  = DISP_ABOVE;
    end
  end

  // offset to unsigned, divide by reciprocal, then shift back to a floor split
  assign u    = {~clamped[VAL_W-1], clamped[VAL_W-2:0]};
  assign prod = u * DIV_RECIP;
  assign q_u  = prod[DIV_RSH+VAL_W-1:DIV_RSH];
  assign qd   = q_u * DIV_D;
  assign r_u  = REM_W'(u - qd);
  assign r_t  = $signed({1'b0, r_u}) - $signed(DIV_OFS_R);
  assign q_t  = $signed({1'b0, q_u}) - $signed(DIV_OFS_Q);

  always_comb begin
    prep_o.channel = in_word_i.channel;
    prep_o.fail    = (s == FAIL_CODE);
    prep_o.raw     = s;
    prep_o.region  = region;
    prep_o.reload  = (in_word_i.channel == CH_OUTSIDE) ? '0 : lo;
    if (r_t < 0) begin
      prep_o.rem = REM_W'(r_t + $signed(OS_REM));
      prep_o.quo = q_t - QUO_W'(1);
    end else begin
      prep_o.rem = REM_W'(r_t);
      prep_o.quo = q_t;
    end
  end

endmodule

// ===== hw/rtl/scc_mem.sv =====
// per-channel state memory, one write and one registered read per cycle
// depends on scc_pkg; entries never written read back as the reset record
module scc_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [scc_pkg::CH_W-1:0]    rd_addr_i,
  output scc_pkg::rec_t               rd_data_o,
  input  logic                        wr_en_i,
  input  logic [scc_pkg::CH_W-1:0]    wr_addr_i,
  input  scc_pkg::rec_t               wr_data_i
);
  import scc_pkg::*;

  rec_t              mem_q [NUM_CH];
  rec_t              rd_q;
  logic [NUM_CH-1:0] vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : REC_RESET;

endmodule

// ===== hw/rtl/scc_update.sv =====
// state update of one word: fail reload, priming, block accumulate, filter step
// depends on scc_pkg
module scc_update (
  input  scc_pkg::prep_t    prep_i,
  input  scc_pkg::rec_t     cur_i,
  output scc_pkg::rec_t     nxt_o,
  output scc_pkg::out_word_t out_o
);
  import scc_pkg::*;

  logic [REM_W:0]          rsum;
  logic                    carry;
  logic signed [QUO_W-1:0] avg;
  logic signed [QUO_W:0]   diff;
  logic signed [ALPHA_W:0] alpha;
  logic signed [QUO_W+ALPHA_W+1:0] prod, prod_adj;
  logic [VAL_W-1:0]        delta;
  logic                    newavg;

  assign rsum  = {1'b0, cur_i.rem} + {1'b0, prep_i.rem};
  assign carry = (rsum >= OS_REM);

  // block average truncated toward zero from the floor split
  assign avg   = cur_i.quo + $signed({{(QUO_W-1){1'b0}},
                 (cur_i.quo[QUO_W-1] && (cur_i.rem != '0))});
  assign diff  = {avg[QUO_W-1], avg} - {{(QUO_W+1-VAL_W){cur_i.filt[VAL_W-1]}}, cur_i.filt};
  assign alpha = $signed({1'b0, alpha_of(prep_i.channel)});
  assign prod  = alpha * diff;
  assign prod_adj = prod + (prod[QUO_W+ALPHA_W+1] ? (QUO_W+ALPHA_W+2)'(255) : '0);
  assign delta = prod_adj[VAL_W+7:8];

  always_comb begin
    nxt_o  = cur_i;
    newavg = 1'b0;
    if (prep_i.fail) begin
      nxt_o.filt   = prep_i.reload;
      nxt_o.status = DISP_NONE;
      nxt_o.primed = 1'b0;
    end else if (!cur_i.primed) begin
      nxt_o.filt   = prep_i.raw;
      nxt_o.primed = 1'b1;
    end else begin
      nxt_o.status = prep_i.region;
      if (prep_i.region == DISP_IN_RANGE) begin
        nxt_o.shown = cur_i.filt;
      end
      if (cur_i.count >= OS_CNT) begin
        nxt_o.filt  = cur_i.filt + $signed(delta);
        nxt_o.count = '0;
        nxt_o.quo   = '0;
        nxt_o.rem   = '0;
        newavg      = 1'b1;
      end else begin
        nxt_o.rem   = carry ? REM_W'(rsum - OS_REM) : REM_W'(rsum);
        nxt_o.quo   = cur_i.quo + prep_i.quo + $signed({{(QUO_W-1){1'b0}}, carry});
        nxt_o.count = cur_i.count + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_o.out_channel    = prep_i.channel;
    out_o.filtered_value = nxt_o.filt;
    out_o.display_status = nxt_o.status;
    out_o.shown_value    = nxt_o.shown;
    out_o.new_average    = newavg;
  end

endmodule

// ===== hw/rtl/sensor_channel_conditioner_top.sv =====
// sensor channel conditioner: four channels of clamp, block average and filter
// a word passes the s1 and output registers; one word per cycle unless the output
// stalls, bounded by the state memory's registered read and the write-back bypass
// reset: clears pipeline valids, memory entry valid bits and loads the limit defaults
// depends on scc_pkg, scc_prep, scc_mem, scc_update
module sensor_channel_conditioner_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic signed [scc_pkg::VAL_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  scc_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output scc_pkg::out_word_t                out_word_o
);
  import scc_pkg::*;

  prep_t            prep;
  prep_t            s1_prep_q;
  logic             s1_valid_q;
  rec_t             rd_rec, cur, nxt;
  out_word_t        upd_out;
  out_word_t        out_q;
  logic             out_valid_q;
  logic             byp_valid_q;
  logic [CH_W-1:0]  byp_ch_q;
  rec_t             byp_rec_q;
  logic             in_fire, s1_fire;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  scc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .prep_o     (prep)
  );

  scc_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_word_i.channel),
    .rd_data_o (rd_rec),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_prep_q.channel),
    .wr_data_i (nxt)
  );

  // write-back landing on the read edge is not seen by the read
  assign cur = (byp_valid_q && (byp_ch_q == s1_prep_q.channel)) ? byp_rec_q : rd_rec;

  scc_update u_update (
    .prep_i (s1_prep_q),
    .cur_i  (cur),
    .nxt_o  (nxt),
    .out_o  (upd_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q  <= 1'b1;
        byp_valid_q <= s1_fire;
      end else if (s1_fire) begin
        s1_valid_q  <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_prep_q <= prep;
      byp_ch_q  <= s1_prep_q.channel;
      byp_rec_q <= nxt;
    end
    if (s1_fire) begin
      out_q <= upd_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_avg_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.new_average |-> out_word_o.display_status != DISP_NONE)
    else $error("filter step without a display status");

  a_fail_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_prep_q.fail |=>
      out_valid_o && (out_word_o.display_status == DISP_NONE) && !out_word_o.new_average)
    else $error("fail word did not clear the display status");

  a_prime_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_prep_q.fail && !cur.primed |=>
      (out_word_o.filtered_value == $past(s1_prep_q.raw)) && !out_word_o.new_average)
    else $error("priming word did not load the raw sample");

endmodule
